// ===== hw/rtl/hck_pkg.sv =====
`timescale 1ns / 1ps

package hck_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int REG_WIDTH = 31;
  localparam int COEF_WIDTH = 62;

  // sqrt(2)/2 as unsigned Q0.30.
  localparam logic [29:0] SQRT_HALF_Q30 = 30'd759250125;

  localparam logic MODE_FORWARD = 1'b0;
  localparam logic MODE_INVERSE = 1'b1;

  localparam logic CHASSIS_MECANUM = 1'b0;
  localparam logic CHASSIS_OMNI    = 1'b1;

  typedef enum logic [2:0] {
    REG_CHASSIS_KIND       = 3'd0,
    REG_REVERSE_MASK       = 3'd1,
    REG_RADIUS             = 3'd2,
    REG_RADIUS_RECIP       = 3'd3,
    REG_BASE_SUM           = 3'd4,
    REG_BASE_SUM_RECIP     = 3'd5,
    REG_MOUNT_RADIUS       = 3'd6,
    REG_MOUNT_RADIUS_RECIP = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SH_F   = 2'd0,
    SH_F2  = 2'd1,
    SH_2F2 = 2'd2,
    SH_F31 = 2'd3
  } shift_sel_t;

  localparam logic [REG_WIDTH-1:0] RADIUS_RST             = 31'd3277;
  localparam logic [REG_WIDTH-1:0] RADIUS_RECIP_RST       = 31'd1310720;
  localparam logic [REG_WIDTH-1:0] BASE_SUM_RST           = 31'd26214;
  localparam logic [REG_WIDTH-1:0] BASE_SUM_RECIP_RST     = 31'd163840;
  localparam logic [REG_WIDTH-1:0] MOUNT_RADIUS_RST       = 31'd19661;
  localparam logic [REG_WIDTH-1:0] MOUNT_RADIUS_RECIP_RST = 31'd218453;

endpackage

// ===== hw/rtl/holonomic_chassis_kinematics.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake                    Payload
// item     in   item_valid / item_stall      mode, wheel_fl..wheel_rr, body_vx..body_wz
// result   out  result_valid / result_stall  out_vx..out_wz, out_fl..out_rr, saturated
// config   in   cfg_we, no wait              cfg_index, cfg_data
//
// One item is accepted in every cycle while item_stall is low.
// The pipeline has thirteen register stages, three of them the split wide multiply.
// Reset clears every valid bit and loads the configuration registers with their defaults.
// A stalled result holds the output register while the stages behind it fill their
// empty slots, so item_stall rises only once every stage holds an item.

module holonomic_chassis_kinematics
  import hck_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [REG_WIDTH-1:0] cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 mode,
  input  logic signed [31:0]   wheel_fl,
  input  logic signed [31:0]   wheel_fr,
  input  logic signed [31:0]   wheel_rl,
  input  logic signed [31:0]   wheel_rr,
  input  logic signed [31:0]   body_vx,
  input  logic signed [31:0]   body_vy,
  input  logic signed [31:0]   body_wz,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic signed [31:0]   out_vx,
  output logic signed [31:0]   out_vy,
  output logic signed [31:0]   out_wz,
  output logic signed [31:0]   out_fl,
  output logic signed [31:0]   out_fr,
  output logic signed [31:0]   out_rl,
  output logic signed [31:0]   out_rr,
  output logic                 saturated
);

  localparam int NS  = 13;
  localparam int TUW = 64 - FRAC_BITS;
  localparam int TSW = TUW + 1;
  localparam int NSW = ((TSW > 35) ? TSW : 35) + 2;
  localparam int AW  = NSW - 1;
  localparam int AHW = AW - 31;
  localparam int MW  = ((AW > COEF_WIDTH) ? AW : COEF_WIDTH) + 1;
  localparam int PW  = AW + COEF_WIDTH;
  localparam int QW  = PW - FRAC_BITS;
  localparam int VW  = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 1;

  localparam logic [63:0] RND_T  = 64'(1) << (FRAC_BITS - 1);
  localparam logic [63:0] RND_30 = 64'(1) << 29;

  localparam logic [PW-1:0] RND_F   = PW'(1) << (FRAC_BITS - 1);
  localparam logic [PW-1:0] RND_F2  = PW'(1) << (FRAC_BITS + 1);
  localparam logic [PW-1:0] RND_2F2 = PW'(1) << (2 * FRAC_BITS + 1);
  localparam logic [PW-1:0] RND_F31 = PW'(1) << (FRAC_BITS + 30);

  localparam logic [QW-1:0] LIM_POS = {{(QW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = LIM_POS + QW'(1);

  // Configuration registers and the coefficients derived from them.
  logic                  chassis_kind;
  logic [3:0]            reverse_mask;
  logic [REG_WIDTH-1:0]  radius_q;
  logic [REG_WIDTH-1:0]  radius_recip_q;
  logic [REG_WIDTH-1:0]  base_sum_q;
  logic [REG_WIDTH-1:0]  base_sum_recip_q;
  logic [REG_WIDTH-1:0]  mount_radius_q;
  logic [REG_WIDTH-1:0]  mount_radius_recip_q;
  logic [COEF_WIDTH-1:0] coef_mec_wz;
  logic [COEF_WIDTH-1:0] coef_omni_wz;
  logic [COEF_WIDTH-1:0] coef_omni_xy;

  always_ff @(posedge clk) begin
    if (rst) begin
      chassis_kind         <= CHASSIS_MECANUM;
      reverse_mask         <= '0;
      radius_q             <= RADIUS_RST;
      radius_recip_q       <= RADIUS_RECIP_RST;
      base_sum_q           <= BASE_SUM_RST;
      base_sum_recip_q     <= BASE_SUM_RECIP_RST;
      mount_radius_q       <= MOUNT_RADIUS_RST;
      mount_radius_recip_q <= MOUNT_RADIUS_RECIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHASSIS_KIND:       chassis_kind         <= cfg_data[0];
        REG_REVERSE_MASK:       reverse_mask         <= cfg_data[3:0];
        REG_RADIUS:             radius_q             <= cfg_data;
        REG_RADIUS_RECIP:       radius_recip_q       <= cfg_data;
        REG_BASE_SUM:           base_sum_q           <= cfg_data;
        REG_BASE_SUM_RECIP:     base_sum_recip_q     <= cfg_data;
        REG_MOUNT_RADIUS:       mount_radius_q       <= cfg_data;
        REG_MOUNT_RADIUS_RECIP: mount_radius_recip_q <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    coef_mec_wz  <= {31'b0, radius_q} * {31'b0, base_sum_recip_q};
    coef_omni_wz <= {31'b0, radius_q} * {31'b0, mount_radius_recip_q};
    coef_omni_xy <= {31'b0, radius_q} * {32'b0, SQRT_HALF_Q30};
  end

  // Pipeline control: a stage holds only when it and every stage after it are full
  // and the result is stalled.
  logic [NS:1] vld;
  logic [NS:1] load;

  for (genvar k = 1; k <= NS; k++) begin : g_load
    assign load[k] = !(result_stall && (&vld[NS:k]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[1]) begin
        vld[1] <= item_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (load[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign item_stall   = !load[1];
  assign result_valid = vld[NS];

  // Stage 1: capture.
  logic               s1_mode;
  logic signed [31:0] s1_w [4];
  logic signed [31:0] s1_vx, s1_vy, s1_wz;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s1_mode <= mode;
      s1_w[0] <= wheel_fl;
      s1_w[1] <= wheel_fr;
      s1_w[2] <= wheel_rl;
      s1_w[3] <= wheel_rr;
      s1_vx   <= body_vx;
      s1_vy   <= body_vy;
      s1_wz   <= body_wz;
    end
  end

  // Stage 2: wheel reversal and wheel sums; twist sums.
  logic signed [32:0] w_rev [4];
  logic signed [34:0] w_ext [4];
  logic signed [34:0] fs_next [3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w_rev[i] = reverse_mask[i] ? -33'(s1_w[i]) : 33'(s1_w[i]);
      w_ext[i] = 35'(w_rev[i]);
    end
    if (chassis_kind == CHASSIS_OMNI) begin
      fs_next[0] = -w_ext[0] - w_ext[1] + w_ext[2] + w_ext[3];
      fs_next[1] = -w_ext[0] + w_ext[1] - w_ext[2] + w_ext[3];
      fs_next[2] =  w_ext[0] + w_ext[1] + w_ext[2] + w_ext[3];
    end else begin
      fs_next[0] =  w_ext[0] + w_ext[1] + w_ext[2] + w_ext[3];
      fs_next[1] = -w_ext[0] + w_ext[1] + w_ext[2] - w_ext[3];
      fs_next[2] = -w_ext[0] + w_ext[1] - w_ext[2] + w_ext[3];
    end
  end

  logic               s2_mode;
  logic signed [34:0] s2_fs [3];
  logic signed [32:0] s2_a, s2_b;
  logic signed [31:0] s2_wz;

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s2_mode <= s1_mode;
      s2_fs   <= fs_next;
      s2_a    <= 33'(s1_vx) + 33'(s1_vy);
      s2_b    <= 33'(s1_vy) - 33'(s1_vx);
      s2_wz   <= s1_wz;
    end
  end

  // Stage 3: magnitudes and signs.
  logic               s3_mode;
  logic [33:0]        s3_fmag [3];
  logic               s3_fneg [3];
  logic [32:0]        s3_amag, s3_bmag;
  logic               s3_aneg, s3_bneg, s3_wneg;
  logic [31:0]        s3_wmag;
  logic signed [32:0] s3_a, s3_b;

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s3_mode <= s2_mode;
      for (int i = 0; i < 3; i++) begin
        s3_fmag[i] <= s2_fs[i][34] ? 34'(-s2_fs[i]) : 34'(s2_fs[i]);
        s3_fneg[i] <= s2_fs[i][34];
      end
      s3_amag <= s2_a[32] ? 33'(-s2_a) : 33'(s2_a);
      s3_aneg <= s2_a[32];
      s3_bmag <= s2_b[32] ? 33'(-s2_b) : 33'(s2_b);
      s3_bneg <= s2_b[32];
      s3_wmag <= s2_wz[31] ? 32'(-s2_wz) : 32'(s2_wz);
      s3_wneg <= s2_wz[31];
      s3_a    <= s2_a;
      s3_b    <= s2_b;
    end
  end

  // Stage 4: first products of the inverse direction.
  logic [REG_WIDTH-1:0] coef_w;
  assign coef_w = (chassis_kind == CHASSIS_OMNI) ? mount_radius_q : base_sum_q;

  logic               s4_mode;
  logic [33:0]        s4_fmag [3];
  logic               s4_fneg [3];
  logic [62:0]        s4_pw, s4_pm, s4_pd;
  logic               s4_aneg, s4_bneg, s4_wneg;
  logic signed [32:0] s4_a, s4_b;

  always_ff @(posedge clk) begin
    if (load[4]) begin
      s4_mode <= s3_mode;
      s4_fmag <= s3_fmag;
      s4_fneg <= s3_fneg;
      s4_pw   <= {31'b0, s3_wmag} * {32'b0, coef_w};
      s4_pm   <= {30'b0, s3_amag} * {33'b0, SQRT_HALF_Q30};
      s4_pd   <= {30'b0, s3_bmag} * {33'b0, SQRT_HALF_Q30};
      s4_aneg <= s3_aneg;
      s4_bneg <= s3_bneg;
      s4_wneg <= s3_wneg;
      s4_a    <= s3_a;
      s4_b    <= s3_b;
    end
  end

  // Stage 5: rounding of the first products.
  logic [63:0] rsum_w, rsum_m, rsum_d;
  assign rsum_w = {1'b0, s4_pw} + RND_T;
  assign rsum_m = {1'b0, s4_pm} + RND_30;
  assign rsum_d = {1'b0, s4_pd} + RND_30;

  logic               s5_mode;
  logic [33:0]        s5_fmag [3];
  logic               s5_fneg [3];
  logic [TUW-1:0]     s5_tu;
  logic [33:0]        s5_mm, s5_dd;
  logic               s5_mneg, s5_dneg, s5_wneg;
  logic signed [32:0] s5_a, s5_b;

  always_ff @(posedge clk) begin
    if (load[5]) begin
      s5_mode <= s4_mode;
      s5_fmag <= s4_fmag;
      s5_fneg <= s4_fneg;
      s5_tu   <= rsum_w[63:FRAC_BITS];
      s5_mm   <= rsum_m[63:30];
      s5_dd   <= rsum_d[63:30];
      s5_mneg <= s4_aneg;
      s5_dneg <= s4_bneg;
      s5_wneg <= s4_wneg;
      s5_a    <= s4_a;
      s5_b    <= s4_b;
    end
  end

  // Stage 6: signed intermediate terms.
  logic signed [TSW-1:0] tu_ext;
  logic signed [34:0]    mm_ext, dd_ext;
  assign tu_ext = $signed({1'b0, s5_tu});
  assign mm_ext = $signed({1'b0, s5_mm});
  assign dd_ext = $signed({1'b0, s5_dd});

  logic                  s6_mode;
  logic [33:0]           s6_fmag [3];
  logic                  s6_fneg [3];
  logic signed [TSW-1:0] s6_t;
  logic signed [34:0]    s6_m, s6_d;
  logic signed [32:0]    s6_a, s6_b;

  always_ff @(posedge clk) begin
    if (load[6]) begin
      s6_mode <= s5_mode;
      s6_fmag <= s5_fmag;
      s6_fneg <= s5_fneg;
      s6_t    <= s5_wneg ? -tu_ext : tu_ext;
      s6_m    <= s5_mneg ? -mm_ext : mm_ext;
      s6_d    <= s5_dneg ? -dd_ext : dd_ext;
      s6_a    <= s5_a;
      s6_b    <= s5_b;
    end
  end

  // Stage 7: wheel terms before the radius reciprocal.
  logic signed [NSW-1:0] a_e, b_e, t_e, m_e, d_e;
  logic signed [NSW-1:0] n_next [4];

  always_comb begin
    a_e = NSW'(s6_a);
    b_e = NSW'(s6_b);
    t_e = NSW'(s6_t);
    m_e = NSW'(s6_m);
    d_e = NSW'(s6_d);
    if (chassis_kind == CHASSIS_OMNI) begin
      n_next[0] = t_e - m_e;
      n_next[1] = d_e + t_e;
      n_next[2] = t_e - d_e;
      n_next[3] = m_e + t_e;
    end else begin
      n_next[0] = -b_e - t_e;
      n_next[1] = a_e + t_e;
      n_next[2] = a_e - t_e;
      n_next[3] = -b_e + t_e;
    end
  end

  logic                  s7_mode;
  logic [33:0]           s7_fmag [3];
  logic                  s7_fneg [3];
  logic signed [NSW-1:0] s7_n [4];

  always_ff @(posedge clk) begin
    if (load[7]) begin
      s7_mode <= s6_mode;
      s7_fmag <= s6_fmag;
      s7_fneg <= s6_fneg;
      s7_n    <= n_next;
    end
  end

  // Stage 8: lane set-up, one magnitude, sign, coefficient and shift per lane.
  logic [AW-1:0]         lane_mag_next [4];
  logic                  lane_neg_next [4];
  logic [COEF_WIDTH-1:0] lane_coef_next [4];
  shift_sel_t            lane_sh_next [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (s7_mode == MODE_INVERSE) begin
        lane_mag_next[i]  = s7_n[i][NSW-1] ? AW'(-s7_n[i]) : AW'(s7_n[i]);
        lane_neg_next[i]  = s7_n[i][NSW-1] ^ reverse_mask[i];
        lane_coef_next[i] = {31'b0, radius_recip_q};
        lane_sh_next[i]   = SH_F;
      end else begin
        lane_mag_next[i]  = '0;
        lane_neg_next[i]  = 1'b0;
        lane_coef_next[i] = '0;
        lane_sh_next[i]   = SH_F;
      end
    end
    if (s7_mode == MODE_FORWARD) begin
      for (int i = 0; i < 3; i++) begin
        lane_mag_next[i] = AW'(s7_fmag[i]);
        lane_neg_next[i] = s7_fneg[i];
        if (i == 2) begin
          lane_coef_next[i] = (chassis_kind == CHASSIS_OMNI) ? coef_omni_wz : coef_mec_wz;
          lane_sh_next[i]   = SH_2F2;
        end else if (chassis_kind == CHASSIS_OMNI) begin
          lane_coef_next[i] = coef_omni_xy;
          lane_sh_next[i]   = SH_F31;
        end else begin
          lane_coef_next[i] = {31'b0, radius_q};
          lane_sh_next[i]   = SH_F2;
        end
      end
    end
  end

  logic                  s8_mode;
  logic [AW-1:0]         s8_mag [4];
  logic                  s8_neg [4];
  logic [COEF_WIDTH-1:0] s8_coef [4];
  shift_sel_t            s8_sh [4];

  always_ff @(posedge clk) begin
    if (load[8]) begin
      s8_mode <= s7_mode;
      s8_mag  <= lane_mag_next;
      s8_neg  <= lane_neg_next;
      s8_coef <= lane_coef_next;
      s8_sh   <= lane_sh_next;
    end
  end

  // Stage 9: partial products on the operands split at bit 31.
  logic              s9_mode;
  logic [61:0]       s9_pll [4];
  logic [61:0]       s9_plh [4];
  logic [AW-1:0]     s9_phl [4];
  logic [AW-1:0]     s9_phh [4];
  logic              s9_neg [4];
  shift_sel_t        s9_sh [4];

  always_ff @(posedge clk) begin
    if (load[9]) begin
      s9_mode <= s8_mode;
      for (int i = 0; i < 4; i++) begin
        s9_pll[i] <= {31'b0, s8_mag[i][30:0]} * {31'b0, s8_coef[i][30:0]};
        s9_plh[i] <= {31'b0, s8_mag[i][30:0]} * {31'b0, s8_coef[i][61:31]};
        s9_phl[i] <= {{31{1'b0}}, s8_mag[i][AW-1:31]} * {{AHW{1'b0}}, s8_coef[i][30:0]};
        s9_phh[i] <= {{31{1'b0}}, s8_mag[i][AW-1:31]} * {{AHW{1'b0}}, s8_coef[i][61:31]};
      end
      s9_neg <= s8_neg;
      s9_sh  <= s8_sh;
    end
  end

  // Stage 10: middle partial sum; outer products do not overlap.
  logic          s10_mode;
  logic [MW-1:0] s10_mid [4];
  logic [PW-1:0] s10_cat [4];
  logic          s10_neg [4];
  shift_sel_t    s10_sh [4];

  always_ff @(posedge clk) begin
    if (load[10]) begin
      s10_mode <= s9_mode;
      for (int i = 0; i < 4; i++) begin
        s10_mid[i] <= MW'(s9_plh[i]) + MW'(s9_phl[i]);
        s10_cat[i] <= {s9_phh[i], s9_pll[i]};
      end
      s10_neg <= s9_neg;
      s10_sh  <= s9_sh;
    end
  end

  // Stage 11: full product.
  logic          s11_mode;
  logic [PW-1:0] s11_p [4];
  logic          s11_neg [4];
  shift_sel_t    s11_sh [4];

  always_ff @(posedge clk) begin
    if (load[11]) begin
      s11_mode <= s10_mode;
      for (int i = 0; i < 4; i++) begin
        s11_p[i] <= s10_cat[i] + (PW'(s10_mid[i]) << 31);
      end
      s11_neg <= s10_neg;
      s11_sh  <= s10_sh;
    end
  end

  // Stage 12: round to nearest, ties away from zero, and scale.
  logic [PW-1:0] rsum [4];
  logic [QW-1:0] q_next [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (s11_sh[i])
        SH_F: begin
          rsum[i]   = s11_p[i] + RND_F;
          q_next[i] = QW'(rsum[i] >> FRAC_BITS);
        end
        SH_F2: begin
          rsum[i]   = s11_p[i] + RND_F2;
          q_next[i] = QW'(rsum[i] >> (FRAC_BITS + 2));
        end
        SH_2F2: begin
          rsum[i]   = s11_p[i] + RND_2F2;
          q_next[i] = QW'(rsum[i] >> (2 * FRAC_BITS + 2));
        end
        SH_F31: begin
          rsum[i]   = s11_p[i] + RND_F31;
          q_next[i] = QW'(rsum[i] >> (FRAC_BITS + 31));
        end
        default: begin
          rsum[i]   = s11_p[i] + RND_F;
          q_next[i] = QW'(rsum[i] >> FRAC_BITS);
        end
      endcase
    end
  end

  logic          s12_mode;
  logic [QW-1:0] s12_q [4];
  logic          s12_neg [4];

  always_ff @(posedge clk) begin
    if (load[12]) begin
      s12_mode <= s11_mode;
      s12_q    <= q_next;
      s12_neg  <= s11_neg;
    end
  end

  // Stage 13: saturation and the output register.
  logic [3:0]    over;
  logic [QW-1:0] mag_sat [4];
  logic [VW-1:0] mag_v [4];
  logic [VW-1:0] lane_res [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      over[i]     = s12_neg[i] ? (s12_q[i] > LIM_NEG) : (s12_q[i] > LIM_POS);
      mag_sat[i]  = over[i] ? (s12_neg[i] ? LIM_NEG : LIM_POS) : s12_q[i];
      mag_v[i]    = mag_sat[i][VW-1:0];
      lane_res[i] = s12_neg[i] ? VW'(-mag_v[i]) : mag_v[i];
    end
  end

  logic s13_mode;

  always_ff @(posedge clk) begin
    if (load[13]) begin
      s13_mode  <= s12_mode;
      saturated <= |over;
      if (s12_mode == MODE_INVERSE) begin
        out_vx <= '0;
        out_vy <= '0;
        out_wz <= '0;
        out_fl <= lane_res[0][31:0];
        out_fr <= lane_res[1][31:0];
        out_rl <= lane_res[2][31:0];
        out_rr <= lane_res[3][31:0];
      end else begin
        out_vx <= lane_res[0][31:0];
        out_vy <= lane_res[1][31:0];
        out_wz <= lane_res[2][31:0];
        out_fl <= '0;
        out_fr <= '0;
        out_rl <= '0;
        out_rr <= '0;
      end
    end
  end

  a_inverse_twist_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && s13_mode == MODE_INVERSE) |-> (out_vx == '0 && out_vy == '0 && out_wz == '0))
    else $error("Inverse-mode result carries a non-zero twist.");

  a_forward_wheels_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && s13_mode == MODE_FORWARD)
      |-> (out_fl == '0 && out_fr == '0 && out_rl == '0 && out_rr == '0))
    else $error("Forward-mode result carries non-zero wheel commands.");

  a_lone_item_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && vld == '0) |-> ##NS result_valid)
    else $error("An item entering an empty pipeline did not reach the output in time.");

endmodule

// ===== verif/holonomic_chassis_kinematics_tb.sv =====
`timescale 1ns / 1ps

module holonomic_chassis_kinematics_tb;
  import hck_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int NUM_PHASES = 11;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_LEN = 64;
  localparam int TAIL_CYCLES = 40;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [63:0] MAG_CAP = 64'd1 << 62;

  typedef struct packed {
    logic mode;
    logic signed [31:0] fl;
    logic signed [31:0] fr;
    logic signed [31:0] rl;
    logic signed [31:0] rr;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] wz;
  } kin_item_t;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] wz;
    logic signed [31:0] fl;
    logic signed [31:0] fr;
    logic signed [31:0] rl;
    logic signed [31:0] rr;
    logic sat;
  } kin_result_t;

  typedef struct packed {
    logic pinned;
    kin_item_t item;
    kin_result_t want;
  } dir_row_t;

  localparam logic [31:0] W_MAX = 32'h7fffffff;
  localparam logic [31:0] W_MIN = 32'h80000000;
  localparam logic [31:0] W_ONE = 32'h00010000;
  localparam logic [31:0] Z = 32'h0;
  localparam logic [31:0] TWENTY = 32'd1310720;
  localparam kin_result_t ALL_ZERO = '0;

  // Pinned rows hold results for the reset geometry on a mecanum base.
  localparam dir_row_t DIR_ROWS [12] = '{
    {1'b1, MODE_FORWARD, Z, Z, Z, Z, Z, Z, Z, ALL_ZERO},
    {1'b1, MODE_INVERSE, Z, Z, Z, Z, Z, Z, Z, ALL_ZERO},
    {1'b0, MODE_FORWARD, W_MAX, W_MAX, W_MAX, W_MAX, Z, Z, Z, ALL_ZERO},
    {1'b0, MODE_FORWARD, W_MIN, W_MIN, W_MIN, W_MIN, Z, Z, Z, ALL_ZERO},
    {1'b0, MODE_FORWARD, W_MAX, W_MIN, W_MAX, W_MIN, Z, Z, Z, ALL_ZERO},
    {1'b1, MODE_INVERSE, Z, Z, Z, Z, W_MAX, W_MAX, W_MAX,
     Z, Z, Z, W_MIN, W_MAX, W_MAX, W_MAX, 1'b1},
    {1'b1, MODE_INVERSE, Z, Z, Z, Z, W_MIN, W_MIN, W_MIN,
     Z, Z, Z, W_MAX, W_MIN, W_MIN, W_MIN, 1'b1},
    {1'b1, MODE_INVERSE, Z, Z, Z, Z, W_ONE, Z, Z,
     Z, Z, Z, TWENTY, TWENTY, TWENTY, TWENTY, 1'b0},
    {1'b0, MODE_FORWARD, 32'h1, Z, Z, Z, Z, Z, Z, ALL_ZERO},
    {1'b0, MODE_INVERSE, Z, Z, Z, Z, Z, Z, 32'h1, ALL_ZERO},
    {1'b1, MODE_INVERSE, Z, Z, Z, Z, W_MAX, W_MIN, Z,
     Z, Z, Z, W_MAX, 32'hffffffec, 32'hffffffec, W_MAX, 1'b1},
    {1'b0, MODE_FORWARD, W_ONE, 32'hfffe8000, 32'h12345678, 32'h80000001,
     32'h00018000, 32'hffff0001, 32'h7ffeffff, ALL_ZERO}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [REG_WIDTH-1:0] cfg_data;
  logic item_valid;
  logic item_stall;
  logic mode;
  logic signed [31:0] wheel_fl, wheel_fr, wheel_rl, wheel_rr;
  logic signed [31:0] body_vx, body_vy, body_wz;
  logic result_valid;
  logic result_stall;
  logic signed [31:0] out_vx, out_vy, out_wz;
  logic signed [31:0] out_fl, out_fr, out_rl, out_rr;
  logic saturated;

  logic chassis_cfg;
  logic [3:0] rev_cfg;
  logic [REG_WIDTH-1:0] rad_cfg, rad_inv_cfg, bsum_cfg, bsum_inv_cfg;
  logic [REG_WIDTH-1:0] mrad_cfg, mrad_inv_cfg;

  kin_result_t pending_results [$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit hold_off_req = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned settings_used = 1;

  holonomic_chassis_kinematics DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .mode(mode),
    .wheel_fl(wheel_fl),
    .wheel_fr(wheel_fr),
    .wheel_rl(wheel_rl),
    .wheel_rr(wheel_rr),
    .body_vx(body_vx),
    .body_vy(body_vy),
    .body_wz(body_wz),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_vx(out_vx),
    .out_vy(out_vy),
    .out_wz(out_wz),
    .out_fl(out_fl),
    .out_fr(out_fr),
    .out_rl(out_rl),
    .out_rr(out_rr),
    .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // Rounds a * c / 2^sh to nearest with ties away from zero; the magnitude is capped at 2^62.
  function automatic longint scaled_round(longint a, logic [63:0] c, int unsigned sh);
    logic [63:0] mag;
    logic [127:0] acc;
    logic [63:0] r;
    mag = (a < 0) ? -a : a;
    acc = {64'd0, mag} * {64'd0, c};
    acc = acc + (128'd1 << (sh - 1));
    acc = acc >> sh;
    r = (acc > {64'd0, MAG_CAP}) ? MAG_CAP : acc[63:0];
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic kin_result_t solve_kinematics(kin_item_t it);
    longint w [4];
    longint n [4];
    longint res [7];
    longint vx, vy, wz, t, m, d, u, v;
    logic [63:0] gain;
    logic clipped;
    kin_result_t r;
    clipped = 1'b0;
    for (int i = 0; i < 7; i++) res[i] = 0;
    if (it.mode == MODE_FORWARD) begin
      w[0] = it.fl;
      w[1] = it.fr;
      w[2] = it.rl;
      w[3] = it.rr;
      for (int i = 0; i < 4; i++) if (rev_cfg[i]) w[i] = -w[i];
      if (chassis_cfg == CHASSIS_MECANUM) begin
        gain = 64'(rad_cfg) * 64'(bsum_inv_cfg);
        res[0] = scaled_round(w[0] + w[1] + w[2] + w[3], 64'(rad_cfg), FB + 2);
        res[1] = scaled_round(-w[0] + w[1] + w[2] - w[3], 64'(rad_cfg), FB + 2);
        res[2] = scaled_round(-w[0] + w[1] - w[2] + w[3], gain, 2 * FB + 2);
      end else begin
        gain = 64'(rad_cfg) * 64'(SQRT_HALF_Q30);
        res[0] = scaled_round(-w[0] - w[1] + w[2] + w[3], gain, FB + 31);
        res[1] = scaled_round(-w[0] + w[1] - w[2] + w[3], gain, FB + 31);
        gain = 64'(rad_cfg) * 64'(mrad_inv_cfg);
        res[2] = scaled_round(w[0] + w[1] + w[2] + w[3], gain, 2 * FB + 2);
      end
    end else begin
      vx = it.vx;
      vy = it.vy;
      wz = it.wz;
      if (chassis_cfg == CHASSIS_MECANUM) begin
        t = scaled_round(wz, 64'(bsum_cfg), FB);
        n[0] = vx - vy - t;
        n[1] = vx + vy + t;
        n[2] = vx + vy - t;
        n[3] = vx - vy + t;
      end else begin
        m = scaled_round(vx + vy, 64'(SQRT_HALF_Q30), 30);
        d = scaled_round(vy - vx, 64'(SQRT_HALF_Q30), 30);
        u = scaled_round(wz, 64'(mrad_cfg), FB);
        n[0] = -m + u;
        n[1] = d + u;
        n[2] = -d + u;
        n[3] = m + u;
      end
      for (int i = 0; i < 4; i++) begin
        v = scaled_round(n[i], 64'(rad_inv_cfg), FB);
        if (rev_cfg[i]) v = -v;
        res[3 + i] = v;
      end
    end
    for (int i = 0; i < 7; i++) begin
      if (res[i] > S32_MAX) begin
        res[i] = S32_MAX;
        clipped = 1'b1;
      end else if (res[i] < S32_MIN) begin
        res[i] = S32_MIN;
        clipped = 1'b1;
      end
    end
    r.vx = res[0][31:0];
    r.vy = res[1][31:0];
    r.wz = res[2][31:0];
    r.fl = res[3][31:0];
    r.fr = res[4][31:0];
    r.rl = res[5][31:0];
    r.rr = res[6][31:0];
    r.sat = clipped;
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return W_MAX;
      1: return W_MIN;
      2: return Z;
      3, 4, 5: return $urandom_range(0, 2097152) - 32'd1048576;
      default: return $urandom();
    endcase
  endfunction

  function automatic kin_item_t random_item();
    kin_item_t it;
    it.mode = $urandom_range(0, 1);
    it.fl = pick_word();
    it.fr = pick_word();
    it.rl = pick_word();
    it.rr = pick_word();
    it.vx = pick_word();
    it.vy = pick_word();
    it.wz = pick_word();
    return it;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch on result %0d: %s", $realtime, results_checked, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    kin_result_t got;
    kin_result_t want;
    if (!rst && result_valid && !result_stall) begin
      got = {out_vx, out_vy, out_wz, out_fl, out_fr, out_rl, out_rr, saturated};
      if (pending_results.size() == 0) begin
        flag_mismatch("result arrived with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("out_vx", got.vx, want.vx);
        check_field("out_vy", got.vy, want.vy);
        check_field("out_wz", got.wz, want.wz);
        check_field("out_fl", got.fl, want.fl);
        check_field("out_fr", got.fr, want.fr);
        check_field("out_rl", got.rl, want.rl);
        check_field("out_rr", got.rr, want.rr);
        check_field("saturated", {31'd0, got.sat}, {31'd0, want.sat});
        results_checked++;
      end
    end
  end

  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_off_req = 1'b0;
      end
      result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  task automatic send_item(kin_item_t it, logic pinned, kin_result_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    mode <= it.mode;
    wheel_fl <= it.fl;
    wheel_fr <= it.fr;
    wheel_rl <= it.rl;
    wheel_rr <= it.rr;
    body_vx <= it.vx;
    body_vy <= it.vy;
    body_wz <= it.wz;
    @(posedge clk);
    while (item_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    pending_results.push_back(pinned ? want : solve_kinematics(it));
    items_sent++;
  endtask

  task automatic idle_item();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [REG_WIDTH-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CHASSIS_KIND: chassis_cfg = val[0];
      REG_REVERSE_MASK: rev_cfg = val[3:0];
      REG_RADIUS: rad_cfg = val;
      REG_RADIUS_RECIP: rad_inv_cfg = val;
      REG_BASE_SUM: bsum_cfg = val;
      REG_BASE_SUM_RECIP: bsum_inv_cfg = val;
      REG_MOUNT_RADIUS: mrad_cfg = val;
      REG_MOUNT_RADIUS_RECIP: mrad_inv_cfg = val;
      default: ;
    endcase
  endtask

  task automatic program_setting(int unsigned sel);
    logic [REG_WIDTH-1:0] kind_word;
    logic [REG_WIDTH-1:0] mask_word;
    logic [REG_WIDTH-1:0] geo [6];
    kind_word = REG_WIDTH'($urandom_range(0, 1));
    mask_word = REG_WIDTH'($urandom_range(0, 15));
    for (int i = 0; i < 6; i++) geo[i] = REG_WIDTH'($urandom_range(1 << 10, 1 << 22));
    case (sel)
      0: begin
        kind_word = REG_WIDTH'(CHASSIS_MECANUM);
        mask_word = '0;
        geo[0] = RADIUS_RST;
        geo[1] = RADIUS_RECIP_RST;
        geo[2] = BASE_SUM_RST;
        geo[3] = BASE_SUM_RECIP_RST;
        geo[4] = MOUNT_RADIUS_RST;
        geo[5] = MOUNT_RADIUS_RECIP_RST;
      end
      1: kind_word = REG_WIDTH'(CHASSIS_OMNI);
      2: for (int i = 0; i < 6; i++) geo[i] = '0;
      3: begin
        kind_word = REG_WIDTH'(CHASSIS_MECANUM);
        mask_word = REG_WIDTH'(4'hF);
        for (int i = 0; i < 6; i++) geo[i] = '1;
      end
      4: begin
        kind_word = REG_WIDTH'(CHASSIS_OMNI);
        mask_word = '0;
        for (int i = 0; i < 6; i++) geo[i] = '1;
      end
      5: begin
        kind_word = REG_WIDTH'($urandom());
        mask_word = REG_WIDTH'($urandom());
        for (int i = 0; i < 6; i++) geo[i] = REG_WIDTH'($urandom());
      end
      default: ;
    endcase
    cfg_write(REG_CHASSIS_KIND, kind_word);
    cfg_write(REG_REVERSE_MASK, mask_word);
    cfg_write(REG_RADIUS, geo[0]);
    cfg_write(REG_RADIUS_RECIP, geo[1]);
    cfg_write(REG_BASE_SUM, geo[2]);
    cfg_write(REG_BASE_SUM_RECIP, geo[3]);
    cfg_write(REG_MOUNT_RADIUS, geo[4]);
    cfg_write(REG_MOUNT_RADIUS_RECIP, geo[5]);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned k;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    mode = MODE_FORWARD;
    wheel_fl = '0;
    wheel_fr = '0;
    wheel_rl = '0;
    wheel_rr = '0;
    body_vx = '0;
    body_vy = '0;
    body_wz = '0;
    chassis_cfg = CHASSIS_MECANUM;
    rev_cfg = '0;
    rad_cfg = RADIUS_RST;
    rad_inv_cfg = RADIUS_RECIP_RST;
    bsum_cfg = BASE_SUM_RST;
    bsum_inv_cfg = BASE_SUM_RECIP_RST;
    mrad_cfg = MOUNT_RADIUS_RST;
    mrad_inv_cfg = MOUNT_RADIUS_RECIP_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < 12; k++) send_item(DIR_ROWS[k].item, DIR_ROWS[k].pinned, DIR_ROWS[k].want);
    idle_item();
    wait_drained();
    // The same rows again on an omni base with every wheel reversed.
    cfg_write(REG_CHASSIS_KIND, REG_WIDTH'(CHASSIS_OMNI));
    cfg_write(REG_REVERSE_MASK, REG_WIDTH'(4'hF));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    for (k = 0; k < 12; k++) send_item(DIR_ROWS[k].item, 1'b0, ALL_ZERO);

    for (p = 0; p < NUM_PHASES; p++) begin
      idle_item();
      wait_drained();
      program_setting(p);
      if (p < 4) begin
        tx_idle_pct = 12;
        rx_idle_pct = 76;
      end else if (p < 8) begin
        tx_idle_pct = 76;
        rx_idle_pct = 12;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == 8) hold_off_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 9 && k == PHASE_ITEMS / 2) begin
          idle_item();
          wait_drained();
        end
        send_item(random_item(), 1'b0, ALL_ZERO);
      end
    end

    idle_item();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d items in both modes on both chassis kinds under %0d register settings.",
             items_sent, settings_used);
    $display("Checked %0d results; the input was stalled on %0d cycles.",
             results_checked, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/hck_pkg.sv
hw/rtl/holonomic_chassis_kinematics.sv
verif/holonomic_chassis_kinematics_tb.sv
